// File: rtl/core/cube_map_face_cell_select_core_macros.svh
// Assertion helpers for the cube map face select core.
`ifndef CUBE_MAP_FACE_CELL_SELECT_CORE_MACROS_SVH
`define CUBE_MAP_FACE_CELL_SELECT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMFCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMFCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cmfcs_pkg.sv
`default_nettype none
package cmfcs_pkg;

    localparam int COORD_BITS     = 16;
    localparam int MAX_RESOLUTION = 4096;
    localparam int RES_BITS       = 13;
    localparam int CELL_BITS      = 12;
    localparam int MAG_BITS       = 16;
    localparam int QUO_BITS       = COORD_BITS + 1;
    localparam int DIV_CELLS      = QUO_BITS;
    localparam int ADDR_BITS      = 3;

    localparam logic [ADDR_BITS-1:0] ADDR_FACE_RES = 3'd0;
    localparam logic [RES_BITS-1:0]  RES_RESET     = 13'd256;

    localparam logic [2:0] FACE_POS_Z = 3'd0;
    localparam logic [2:0] FACE_NEG_Z = 3'd1;
    localparam logic [2:0] FACE_POS_X = 3'd2;
    localparam logic [2:0] FACE_NEG_X = 3'd3;
    localparam logic [2:0] FACE_POS_Y = 3'd4;
    localparam logic [2:0] FACE_NEG_Y = 3'd5;

    localparam logic [COORD_BITS-1:0] COORD_CENTER = 16'h8000;
    localparam logic [COORD_BITS-1:0] COORD_MAX    = 16'hFFFF;

    // One word in flight through the divider chain.
    typedef struct packed {
        logic                  valid;
        logic [2:0]            face;
        logic                  zero;
        logic [MAG_BITS-1:0]   m;
        logic [MAG_BITS-1:0]   ru;
        logic [MAG_BITS-1:0]   rv;
        logic [1:0]            fu;
        logic [1:0]            fv;
        logic [QUO_BITS-1:0]   qu;
        logic [QUO_BITS-1:0]   qv;
    } div_word_t;

endpackage
`default_nettype wire

// File: rtl/core/cmfcs_if.sv
`default_nettype none
interface cmfcs_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmfcs_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  face;
    logic [15:0] u_coord;
    logic [15:0] v_coord;
    logic [11:0] cell_col;
    logic [11:0] cell_row;
    logic        zero_vector;
    modport source (output valid, face, u_coord, v_coord, cell_col, cell_row, zero_vector,
                    input ready);
    modport sink   (input valid, face, u_coord, v_coord, cell_col, cell_row, zero_vector,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/core/cmfcs_front.sv
`default_nettype none
module cmfcs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid,
    input  wire logic signed [15:0] dir_x,
    input  wire logic signed [15:0] dir_y,
    input  wire logic signed [15:0] dir_z,
    output cmfcs_pkg::div_word_t    word
);

    logic signed [16:0] x, y, z;
    logic [16:0]        ax, ay, az, m;
    logic [2:0]         face;
    logic signed [16:0] cx, cy;
    logic signed [18:0] nu, nv;
    cmfcs_pkg::div_word_t word_reg, word_next;

    always_comb
    begin
        x  = 17'(dir_x);
        y  = 17'(dir_y);
        z  = 17'(dir_z);
        ax = x[16] ? 17'(-x) : 17'(x);
        ay = y[16] ? 17'(-y) : 17'(y);
        az = z[16] ? 17'(-z) : 17'(z);
        // Ties go to z, then x.
        m    = az;
        face = z[16] ? cmfcs_pkg::FACE_NEG_Z : cmfcs_pkg::FACE_POS_Z;
        if (ax > m)
        begin
            m    = ax;
            face = x[16] ? cmfcs_pkg::FACE_NEG_X : cmfcs_pkg::FACE_POS_X;
        end
        if (ay > m)
        begin
            m    = ay;
            face = y[16] ? cmfcs_pkg::FACE_NEG_Y : cmfcs_pkg::FACE_POS_Y;
        end
        case (face)
            cmfcs_pkg::FACE_POS_Z: begin cx = x;             cy = y;             end
            cmfcs_pkg::FACE_NEG_Z: begin cx = 17'(-x);       cy = y;             end
            cmfcs_pkg::FACE_POS_X: begin cx = 17'(-z);       cy = y;             end
            cmfcs_pkg::FACE_NEG_X: begin cx = z;             cy = y;             end
            cmfcs_pkg::FACE_POS_Y: begin cx = x;             cy = 17'(-z);       end
            default:               begin cx = x;             cy = z;             end
        endcase
        nu = 19'($signed({2'b00, m})) + 19'(cx);
        nv = 19'($signed({2'b00, m})) - 19'(cy);

        word_next.valid = valid;
        word_next.face  = (m == 17'd0) ? cmfcs_pkg::FACE_POS_Z : face;
        word_next.zero  = (m == 17'd0);
        word_next.m     = m[15:0] | {m[16], 15'd0};
        // The numerators lie in [0, 2m]; the first remainder is n/4, below m.
        word_next.ru    = {1'b0, nu[16:2]};
        word_next.rv    = {1'b0, nv[16:2]};
        word_next.fu    = nu[1:0];
        word_next.fv    = nv[1:0];
        word_next.qu    = '0;
        word_next.qv    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule
`default_nettype wire

// File: rtl/core/cmfcs_div_cell.sv
`default_nettype none
module cmfcs_div_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire cmfcs_pkg::div_word_t d,
    output cmfcs_pkg::div_word_t      q
);

    logic [16:0] tu, tv;
    logic        bu, bv;
    cmfcs_pkg::div_word_t word_reg, word_next;

    // One restoring division step for u and v against the shared divisor.
    always_comb
    begin
        tu = {d.ru, d.fu[1]};
        tv = {d.rv, d.fv[1]};
        bu = (tu >= {1'b0, d.m});
        bv = (tv >= {1'b0, d.m});
        word_next    = d;
        word_next.ru = bu ? 16'(tu - {1'b0, d.m}) : tu[15:0];
        word_next.rv = bv ? 16'(tv - {1'b0, d.m}) : tv[15:0];
        word_next.fu = {d.fu[0], 1'b0};
        word_next.fv = {d.fv[0], 1'b0};
        word_next.qu = {d.qu[cmfcs_pkg::QUO_BITS-2:0], bu};
        word_next.qv = {d.qv[cmfcs_pkg::QUO_BITS-2:0], bv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule
`default_nettype wire

// File: rtl/core/cmfcs_back.sv
`default_nettype none
module cmfcs_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire cmfcs_pkg::div_word_t d,
    input  wire logic [12:0]          res,
    output logic                      valid,
    output logic [2:0]                face,
    output logic [15:0]               u_coord,
    output logic [15:0]               v_coord,
    output logic [11:0]               cell_col,
    output logic [11:0]               cell_row,
    output logic                      zero_vector
);

    logic [15:0] u_next, v_next;
    logic [28:0] pu, pv;
    logic [12:0] cu, cv, lim;
    logic [11:0] col_next, row_next;
    logic        valid_reg;
    logic [2:0]  face_reg;
    logic [15:0] u_reg, v_reg;
    logic [11:0] col_reg, row_reg;
    logic        zero_reg;

    always_comb
    begin
        if (d.zero)
        begin
            u_next = cmfcs_pkg::COORD_CENTER;
            v_next = cmfcs_pkg::COORD_CENTER;
        end
        else
        begin
            u_next = d.qu[16] ? cmfcs_pkg::COORD_MAX : d.qu[15:0];
            v_next = d.qv[16] ? cmfcs_pkg::COORD_MAX : d.qv[15:0];
        end
        pu  = 29'(u_next) * 29'(res);
        pv  = 29'(v_next) * 29'(res);
        cu  = pu[28:16];
        cv  = pv[28:16];
        lim = 13'(res - 13'd1);
        col_next = (cu > lim) ? lim[11:0] : cu[11:0];
        row_next = (cv > lim) ? lim[11:0] : cv[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face_reg <= d.face;
            zero_reg <= d.zero;
            u_reg    <= u_next;
            v_reg    <= v_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    assign valid       = valid_reg;
    assign face        = face_reg;
    assign u_coord     = u_reg;
    assign v_coord     = v_reg;
    assign cell_col    = col_reg;
    assign cell_row    = row_reg;
    assign zero_vector = zero_reg;

endmodule
`default_nettype wire

// File: rtl/core/cube_map_face_cell_select_core.sv
`default_nettype none
`include "cube_map_face_cell_select_core_macros.svh"
// Cube map face and cell select. A new direction word can follow every cycle while the result
// side does not stall. The pipeline is a face-select register, then 17 identical divider
// cells that each resolve one quotient bit of u and v against the major magnitude, then a
// final register that saturates the coordinates and scales them by the face resolution.
// A stall on the result side freezes the whole pipeline, so the input is ready whenever the
// output register is empty or being taken.
// face_resolution lives at byte address 0 and should be written only while the block is idle.
module cube_map_face_cell_select_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cmfcs_req_if.sink        req,
    cmfcs_rsp_if.source      rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        en;
    logic [12:0] res_reg, res_eff;
    cmfcs_pkg::div_word_t chain [0:cmfcs_pkg::DIV_CELLS];

    assign pready = 1'b1;
    assign prdata = (paddr == cmfcs_pkg::ADDR_FACE_RES) ? {19'd0, res_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= cmfcs_pkg::RES_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == cmfcs_pkg::ADDR_FACE_RES)
        begin
            res_reg <= pwdata[12:0];
        end
    end

    // Zero counts as one cell; anything above the maximum is held there.
    always_comb
    begin
        if (res_reg == 13'd0)
            res_eff = 13'd1;
        else if (res_reg > 13'(cmfcs_pkg::MAX_RESOLUTION))
            res_eff = 13'(cmfcs_pkg::MAX_RESOLUTION);
        else
            res_eff = res_reg;
    end

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    cmfcs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (req.valid),
        .dir_x (req.dir_x),
        .dir_y (req.dir_y),
        .dir_z (req.dir_z),
        .word  (chain[0])
    );

    for (genvar i = 0; i < cmfcs_pkg::DIV_CELLS; i++)
    begin : g_cell
        cmfcs_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    cmfcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .d           (chain[cmfcs_pkg::DIV_CELLS]),
        .res         (res_eff),
        .valid       (rsp.valid),
        .face        (rsp.face),
        .u_coord     (rsp.u_coord),
        .v_coord     (rsp.v_coord),
        .cell_col    (rsp.cell_col),
        .cell_row    (rsp.cell_row),
        .zero_vector (rsp.zero_vector)
    );

    `CMFCS_ASSERT_NOW(a_face_range, rsp.valid,
        rsp.face <= cmfcs_pkg::FACE_NEG_Y, "face out of range")
    `CMFCS_ASSERT_NOW(a_zero_center, rsp.valid && rsp.zero_vector,
        rsp.face == cmfcs_pkg::FACE_POS_Z && rsp.u_coord == cmfcs_pkg::COORD_CENTER
        && rsp.v_coord == cmfcs_pkg::COORD_CENTER, "zero vector not centered")
    `CMFCS_ASSERT_NOW(a_stall_blocks, rsp.valid && !rsp.ready,
        !req.ready, "input taken during output stall")
    `CMFCS_ASSERT_NOW(a_cell_limit, rsp.valid,
        rsp.cell_col < res_eff && rsp.cell_row < res_eff, "cell beyond resolution")

endmodule
`default_nettype wire

// File: test/tb_scoreboard.sv
class cube_face_scoreboard;
    typedef struct {
        logic [2:0]  face;
        logic [15:0] u_coord;
        logic [15:0] v_coord;
        logic [11:0] cell_col;
        logic [11:0] cell_row;
        logic        zero_vector;
    } face_cell_t;

    face_cell_t pending_q[$];
    int unsigned resolution;
    int unsigned errors;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned zero_seen;
    int unsigned face_seen[6];

    function new();
        resolution = 256;
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
        errors++;
        $display("MISMATCH %s got %0d expected %0d (word %0d)", what, got, want, words_out);
    endfunction

    // Floor of num * 2^15 / m, held below 1.0.
    function int unsigned coord_of(int num, int m);
        longint unsigned q;
        q = (longint'(num) << 15) / longint'(m);
        return (q > 65535) ? 65535 : int'(q);
    endfunction

    function int unsigned cell_of(int unsigned c, int unsigned res);
        longint unsigned scaled;
        scaled = (longint'(c) * res) >> 16;
        return (scaled > res - 1) ? res - 1 : int'(scaled);
    endfunction

    function void note_direction(logic signed [15:0] dx, logic signed [15:0] dy,
                                 logic signed [15:0] dz);
        face_cell_t e;
        int x, y, z, ax, ay, az, m, cx, cy;
        logic [2:0] f;
        int unsigned res;
        x = dx;
        y = dy;
        z = dz;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        m = az;
        f = cmfcs_pkg::FACE_POS_Z;
        if (ax > m) begin m = ax; f = cmfcs_pkg::FACE_POS_X; end
        if (ay > m) begin m = ay; f = cmfcs_pkg::FACE_POS_Y; end
        if (f == cmfcs_pkg::FACE_POS_Z && z < 0) f = cmfcs_pkg::FACE_NEG_Z;
        if (f == cmfcs_pkg::FACE_POS_X && x < 0) f = cmfcs_pkg::FACE_NEG_X;
        if (f == cmfcs_pkg::FACE_POS_Y && y < 0) f = cmfcs_pkg::FACE_NEG_Y;
        case (f)
            cmfcs_pkg::FACE_POS_Z: begin cx = x;  cy = y;  end
            cmfcs_pkg::FACE_NEG_Z: begin cx = -x; cy = y;  end
            cmfcs_pkg::FACE_POS_X: begin cx = -z; cy = y;  end
            cmfcs_pkg::FACE_NEG_X: begin cx = z;  cy = y;  end
            cmfcs_pkg::FACE_POS_Y: begin cx = x;  cy = -z; end
            default:               begin cx = x;  cy = z;  end
        endcase
        if (m == 0) begin
            e.zero_vector = 1'b1;
            e.face = cmfcs_pkg::FACE_POS_Z;
            e.u_coord = cmfcs_pkg::COORD_CENTER;
            e.v_coord = cmfcs_pkg::COORD_CENTER;
        end
        else begin
            e.zero_vector = 1'b0;
            e.face = f;
            e.u_coord = 16'(coord_of(m + cx, m));
            e.v_coord = 16'(coord_of(m - cy, m));
        end
        res = resolution == 0 ? 1 : (resolution > 4096 ? 4096 : resolution);
        e.cell_col = 12'(cell_of(e.u_coord, res));
        e.cell_row = 12'(cell_of(e.v_coord, res));
        pending_q.push_back(e);
        words_in++;
    endfunction

    function void check_result(logic [2:0] f, logic [15:0] u, logic [15:0] v,
                               logic [11:0] col, logic [11:0] row, logic z);
        face_cell_t e;
        if (pending_q.size() == 0) begin
            errors++;
            $display("MISMATCH result with nothing pending");
            return;
        end
        e = pending_q.pop_front();
        if (f !== e.face) report("face", f, e.face);
        if (u !== e.u_coord) report("u_coord", u, e.u_coord);
        if (v !== e.v_coord) report("v_coord", v, e.v_coord);
        if (col !== e.cell_col) report("cell_col", col, e.cell_col);
        if (row !== e.cell_row) report("cell_row", row, e.cell_row);
        if (z !== e.zero_vector) report("zero_vector", z, e.zero_vector);
        if (e.zero_vector) zero_seen++;
        if (e.face < 6) face_seen[e.face]++;
        words_out++;
    endfunction
endclass

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        stall_mode;
    int unsigned stall_pct;

    cmfcs_req_if req ();
    cmfcs_rsp_if rsp ();

    cube_map_face_cell_select_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cube_face_scoreboard board;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    // Accepted result words, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result(rsp.face, rsp.u_coord, rsp.v_coord, rsp.cell_col,
                               rsp.cell_row, rsp.zero_vector);
    end

    // Receiver stall pattern: phases of no stall, light and heavy stalling.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (stall_mode)
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ($urandom_range(63) == 0)
        begin
            stall_mode <= $urandom_range(2) != 0;
            stall_pct  <= $urandom_range(80);
        end
    end

    task automatic write_resolution(int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= cmfcs_pkg::ADDR_FACE_RES;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.resolution = value & 32'h1FFF;
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // Presents one word at the falling edge and holds it until accepted.
    task automatic send_direction(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        @(negedge clk);
        req.valid <= 1'b1;
        req.dir_x <= x;
        req.dir_y <= y;
        req.dir_z <= z;
        forever
        begin
            @(posedge clk);
            if (req.ready) break;
        end
        board.note_direction(x, y, z);
    endtask

    task automatic idle_sender(int unsigned cycles);
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(7) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(int unsigned count);
        int unsigned left;
        int unsigned burst;
        logic [15:0] a;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++)
            begin
                a = rand_comp();
                // Some words tie magnitudes to exercise the priority order.
                case ($urandom_range(5))
                    0: send_direction(a, -a, rand_comp());
                    1: send_direction(rand_comp(), a, a);
                    2: send_direction(a, rand_comp(), -a);
                    default: send_direction(rand_comp(), rand_comp(), rand_comp());
                endcase
            end
            left -= burst;
            if ($urandom_range(2) != 0) idle_sender($urandom_range(1, 12));
        end
        idle_sender(0);
    endtask

    initial
    begin
        int unsigned res_list[7];
        board = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_mode = 1'b0;
        stall_pct = 0;
        req.valid = 1'b0;
        req.dir_x = '0;
        req.dir_y = '0;
        req.dir_z = '0;
        rsp.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every face, ties, zero vector, extremes, at reset resolution.
        send_direction(16'h0000, 16'h0000, 16'h0000);
        send_direction(16'h0100, 16'h0200, 16'h7FFF);
        send_direction(16'h0100, 16'h0200, 16'h8000);
        send_direction(16'h7FFF, 16'h0100, 16'h0200);
        send_direction(16'h8000, 16'h0100, 16'h0200);
        send_direction(16'h0100, 16'h7FFF, 16'h0200);
        send_direction(16'h0100, 16'h8000, 16'h0200);
        send_direction(16'h8000, 16'h8000, 16'h8000);
        send_direction(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_direction(16'h7FFF, 16'h8000, 16'h0000);
        send_direction(16'h8000, 16'h7FFF, 16'h7FFF);
        send_direction(16'h0000, 16'h0001, 16'h0000);
        send_direction(16'hFFFF, 16'h0000, 16'h0000);
        send_direction(16'h0005, 16'hFFFB, 16'h0005);
        send_direction(16'h8000, 16'h7FFF, 16'h8000);
        send_direction(16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_sender(0);
        // The sender holds off here until every pending result is back.
        drain();

        res_list = '{1, 4096, 0, 8191, 3, 1000, 256};
        foreach (res_list[r])
        begin
            write_resolution(res_list[r]);
            send_direction(16'h0000, 16'h0000, 16'h0000);
            send_direction(16'h8000, 16'h7FFF, 16'h8000);
            random_burst(75);
            drain();
        end

        $display("Sent %0d directions, checked %0d results, %0d zero vectors.",
                 board.words_in, board.words_out, board.zero_seen);
        $display("Faces hit: %0d %0d %0d %0d %0d %0d over seven resolution settings.",
                 board.face_seen[0], board.face_seen[1], board.face_seen[2],
                 board.face_seen[3], board.face_seen[4], board.face_seen[5]);
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
